>>> sv/quad_and_line_vertex_generator_macros.svh
// assertion macros for the quad and line vertex generator
// used by the modules that carry concurrent checks, expects clk_i and rst_ni in scope
`ifndef QUAD_AND_LINE_VERTEX_GENERATOR_MACROS_SVH
`define QUAD_AND_LINE_VERTEX_GENERATOR_MACROS_SVH

// property must hold at every clock edge out of reset
`define QLV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen out of reset
`define QLV_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> sv/qlvg_pkg.sv
// shared types, widths and helpers for the quad and line vertex generator
// no dependencies
package qlvg_pkg;

  // coordinate and index widths
  localparam int CW       = 24;
  localparam int IDX_W    = 32;
  localparam int TEX_W    = 16;
  localparam int COL_W    = 32;
  localparam int TYPE_W   = 2;

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_QUAD  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SKEW  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_LINE  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd3;

  // stream payload widths
  localparam int IN_W        = 5 * CW + COL_W + 4 * TEX_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 2 * CW + COL_W + 2 * TEX_W + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // line normal datapath
  localparam int MAG_W      = CW + 1;
  localparam int EXT_W      = 34;
  localparam int NRM_W      = 32;
  localparam int PROD_W     = 64;
  localparam int NUM_W      = CW + 33;
  localparam int REM_W      = 34;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int ROOT_STEPS = 32;
  localparam int SUM_W      = CW + 3;
  localparam int NV_W       = CW + 2;

  localparam logic [TEX_W-1:0] TEX_ONE  = 16'h8000;
  localparam logic [TEX_W-1:0] TEX_ZERO = 16'h0000;

  // output sequence
  localparam int NUM_RES = 10;
  localparam int STEP_W  = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_RES - 1);
  localparam logic [STEP_W-1:0] NUM_VTX   = 4'd4;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [TEX_W-1:0]     u;
    logic [TEX_W-1:0]     v;
  } vtx_t;

  // one queued primitive, or a counter clear
  typedef struct packed {
    logic             is_clear;
    logic [COL_W-1:0] color;
    vtx_t [3:0]       vtx;
  } desc_t;

  // saturate a widened sum to the coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {3'b000, 1'b0, {(CW-1){1'b1}}};
    lo = {3'b111, 1'b1, {(CW-1){1'b0}}};
    if (s > hi) begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end else if (s < lo) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_coord = s[CW-1:0];
    end
  endfunction

  // index offset for the six triangle indices
  function automatic logic [1:0] idx_off(input logic [STEP_W-1:0] step);
    case (step)
      4'd5:    idx_off = 2'd1;
      4'd6:    idx_off = 2'd2;
      4'd8:    idx_off = 2'd2;
      4'd9:    idx_off = 2'd3;
      default: idx_off = 2'd0;
    endcase
  endfunction

endpackage

>>> sv/qlvg_front.sv
// front end: accepts requests, classifies them, works out line normals
// and builds the four vertices; depends on qlvg_pkg
module qlvg_front import qlvg_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic [TYPE_W-1:0]         req_type_i,
  input  logic [IN_TDATA_W-1:0]     req_data_i,
  output logic                      desc_valid_o,
  input  logic                      desc_ready_i,
  output desc_t                     desc_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_NORM = 10'b0000000010,
    ST_SQX  = 10'b0000000100,
    ST_SQY  = 10'b0000001000,
    ST_ADD  = 10'b0000010000,
    ST_ROOT = 10'b0000100000,
    ST_MUL  = 10'b0001000000,
    ST_PREP = 10'b0010000000,
    ST_DIV  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [TYPE_W-1:0]     type_q;
  logic signed [CW-1:0]  ax_q, ay_q, bx_q, by_q, sp_q;
  logic [COL_W-1:0]      color_q;
  logic [TEX_W-1:0]      u0_q, v0_q, u1_q, v1_q;
  logic                  dy_pos_q, dx_neg_q;
  logic [NRM_W-1:0]      mxn_q, myn_q;
  logic [CW-1:0]         mw_q;
  logic [PROD_W-1:0]     prod_q, sum_q, res_q, bit_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NRM_W-1:0]      len_q;
  logic [NUM_W-1:0]      num_q;
  logic [REM_W-1:0]      rem_q;
  logic                  sel_y_q;
  logic signed [NV_W-1:0] nx_q, ny_q;

  // unpack the incoming request
  logic signed [CW-1:0] in_ax, in_ay, in_bx, in_by, in_sp;
  assign in_ax = req_data_i[0*CW +: CW];
  assign in_ay = req_data_i[1*CW +: CW];
  assign in_bx = req_data_i[2*CW +: CW];
  assign in_by = req_data_i[3*CW +: CW];
  assign in_sp = req_data_i[4*CW +: CW];

  logic accept;
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // line direction, magnitudes and short line test
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]        mag_x, mag_y;
  logic [3:0]              small_sq;
  logic                    is_short;
  assign dx    = MAG_W'(in_bx) - MAG_W'(in_ax);
  assign dy    = MAG_W'(in_by) - MAG_W'(in_ay);
  assign mag_x = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign mag_y = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign small_sq = 4'(mag_x[1:0] * mag_x[1:0]) + 4'(mag_y[1:0] * mag_y[1:0]);
  assign is_short = (mag_x < MAG_W'(3)) && (mag_y < MAG_W'(3)) && (small_sq < 4'd7);

  // first normalising step: bring the larger magnitude below 2^31
  logic [EXT_W-1:0] ext_x, ext_y, ext_or, sh_x, sh_y;
  logic             too_big;
  assign ext_x   = EXT_W'(mag_x);
  assign ext_y   = EXT_W'(mag_y);
  assign ext_or  = ext_x | ext_y;
  assign too_big = |ext_or[EXT_W-1:31];
  assign sh_x    = too_big ? (ext_x >> 1) : ext_x;
  assign sh_y    = too_big ? (ext_y >> 1) : ext_y;

  logic [NRM_W-1:0] nrm_or;
  assign nrm_or = mxn_q | myn_q;

  // shared multiplier
  logic [NRM_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    mul_a = mxn_q;
    mul_b = mxn_q;
    if (state_q == ST_SQY) begin
      mul_a = myn_q;
      mul_b = myn_q;
    end else if (state_q == ST_MUL) begin
      mul_a = sel_y_q ? mxn_q : myn_q;
      mul_b = NRM_W'(mw_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // square root step
  logic [PROD_W-1:0] trial, res_nx, sum_nx;
  always_comb begin
    trial = res_q + bit_q;
    if (sum_q >= trial) begin
      sum_nx = sum_q - trial;
      res_nx = (res_q >> 1) + bit_q;
    end else begin
      sum_nx = sum_q;
      res_nx = res_q >> 1;
    end
  end

  // restoring division step
  logic [REM_W-1:0] cand, den;
  logic             ge;
  logic [NUM_W-1:0] num_nx;
  logic signed [NV_W-1:0] qs;
  logic             neg_w;
  assign den    = {1'b0, len_q, 1'b0};
  assign cand   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge     = (cand >= den);
  assign num_nx = {num_q[NUM_W-2:0], ge};
  assign qs     = NV_W'({1'b0, num_nx[CW:0]});
  assign neg_w  = sp_q[CW-1];

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_LINE) begin
            state_d = is_short ? ST_IDLE : ST_NORM;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_NORM: if (nrm_or[31] || nrm_or[30]) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == '0) state_d = ST_MUL;
      ST_MUL:  state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = sel_y_q ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: if (desc_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        type_q   <= req_type_i;
        ax_q     <= in_ax;
        ay_q     <= in_ay;
        bx_q     <= in_bx;
        by_q     <= in_by;
        sp_q     <= in_sp;
        color_q  <= req_data_i[5*CW +: COL_W];
        u0_q     <= req_data_i[5*CW+COL_W +: TEX_W];
        v0_q     <= req_data_i[5*CW+COL_W+TEX_W +: TEX_W];
        u1_q     <= req_data_i[5*CW+COL_W+2*TEX_W +: TEX_W];
        v1_q     <= req_data_i[5*CW+COL_W+3*TEX_W +: TEX_W];
        dy_pos_q <= !dy[MAG_W-1] && (dy != '0);
        dx_neg_q <= dx[MAG_W-1];
        mw_q     <= in_sp[CW-1] ? CW'(-in_sp) : CW'(in_sp);
        mxn_q    <= sh_x[NRM_W-1:0];
        myn_q    <= sh_y[NRM_W-1:0];
        sel_y_q  <= 1'b0;
        nx_q     <= '0;
        ny_q     <= '0;
      end
      ST_NORM: begin
        if (!(nrm_or[31] || nrm_or[30])) begin
          mxn_q <= mxn_q << 1;
          myn_q <= myn_q << 1;
        end
      end
      ST_SQX: prod_q <= mul_p;
      ST_SQY: begin
        sum_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_ADD: begin
        sum_q <= sum_q + prod_q;
        res_q <= '0;
        bit_q <= PROD_W'(1) << 62;
        cnt_q <= CNT_W'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        sum_q <= sum_nx;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - 1'b1;
        len_q <= res_nx[NRM_W-1:0];
      end
      ST_MUL: prod_q <= mul_p;
      ST_PREP: begin
        num_q <= NUM_W'(prod_q) + NUM_W'(len_q);
        rem_q <= '0;
        cnt_q <= CNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        rem_q <= ge ? (cand - den) : cand;
        num_q <= num_nx;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (sel_y_q) begin
            ny_q <= (dx_neg_q != neg_w) ? -qs : qs;
          end else begin
            nx_q    <= (dy_pos_q != neg_w) ? -qs : qs;
            sel_y_q <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // vertex assembly
  logic signed [SUM_W-1:0] sax, say, sbx, sby, ssk, snx, sny;
  assign sax = SUM_W'(ax_q);
  assign say = SUM_W'(ay_q);
  assign sbx = SUM_W'(bx_q);
  assign sby = SUM_W'(by_q);
  assign ssk = (type_q == REQ_SKEW) ? SUM_W'(sp_q) : '0;
  assign snx = SUM_W'(nx_q);
  assign sny = SUM_W'(ny_q);

  always_comb begin
    desc_o.is_clear = (type_q == REQ_CLEAR);
    desc_o.color    = color_q;
    if (type_q == REQ_LINE) begin
      desc_o.vtx[0] = '{sat_coord(sax + snx), sat_coord(say + sny), TEX_ZERO, TEX_ZERO};
      desc_o.vtx[1] = '{sat_coord(sbx + snx), sat_coord(sby + sny), TEX_ONE, TEX_ZERO};
      desc_o.vtx[2] = '{sat_coord(sbx - snx), sat_coord(sby - sny), TEX_ONE, TEX_ONE};
      desc_o.vtx[3] = '{sat_coord(sax - snx), sat_coord(say - sny), TEX_ZERO, TEX_ONE};
    end else begin
      desc_o.vtx[0] = '{sat_coord(sax + ssk), sat_coord(say), u0_q, v0_q};
      desc_o.vtx[1] = '{sat_coord(sax + sbx + ssk), sat_coord(say), u1_q, v0_q};
      desc_o.vtx[2] = '{sat_coord(sax + sbx), sat_coord(say + sby), u1_q, v1_q};
      desc_o.vtx[3] = '{sat_coord(sax), sat_coord(say + sby), u0_q, v1_q};
    end
  end

  assign desc_valid_o = (state_q == ST_EMIT);

endmodule

>>> sv/qlvg_queue.sv
// two-entry queue of primitive descriptors between front and back end
// depends on qlvg_pkg
module qlvg_queue import qlvg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_desc_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_desc_o
);

  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = $clog2(Q_DEPTH);

  desc_t               mem_q [Q_DEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [PTR_W:0]      cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != (PTR_W+1)'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_desc_i;
  end

endmodule

>>> sv/qlvg_back.sv
// back end: plays out four vertices and six indices per primitive and
// keeps the running vertex counter; depends on qlvg_pkg and the macro header
`include "quad_and_line_vertex_generator_macros.svh"
module qlvg_back import qlvg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   desc_valid_i,
  output logic                   desc_ready_o,
  input  desc_t                  desc_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_index_o,
  output logic                   out_last_o
);

  desc_t             desc_q;
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              fire, done, pop;

  assign fire         = busy_q && out_ready_i;
  assign done         = fire && (step_q == LAST_STEP);
  assign desc_ready_o = !busy_q || done;
  assign pop          = desc_valid_i && desc_ready_o;

  // counter: advance at the end of a primitive, clear wins
  always_comb begin
    cnt_d = cnt_q;
    if (done) cnt_d = cnt_q + IDX_W'(4);
    if (pop && desc_i.is_clear) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (fire) step_q <= step_q + 1'b1;
      if (done) busy_q <= 1'b0;
      if (pop && !desc_i.is_clear) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !desc_i.is_clear) desc_q <= desc_i;
  end

  // result selection
  vtx_t             cur;
  logic             is_idx;
  logic [IDX_W-1:0] idx_val;
  assign is_idx  = (step_q >= NUM_VTX);
  assign cur     = desc_q.vtx[step_q[1:0]];
  assign idx_val = cnt_q + IDX_W'(idx_off(step_q));

  always_comb begin
    out_data_o = '0;
    if (is_idx) begin
      out_data_o[2*CW+COL_W+2*TEX_W +: IDX_W] = idx_val;
    end else begin
      out_data_o[0 +: CW]                 = cur.x;
      out_data_o[CW +: CW]                = cur.y;
      out_data_o[2*CW +: COL_W]           = desc_q.color;
      out_data_o[2*CW+COL_W +: TEX_W]     = cur.u;
      out_data_o[2*CW+COL_W+TEX_W +: TEX_W] = cur.v;
    end
  end

  assign out_valid_o = busy_q;
  assign out_index_o = is_idx;
  assign out_last_o  = (step_q == LAST_STEP);

  // checks
  `QLV_ASSERT(a_last_is_index, out_valid_o && out_last_o |-> out_index_o, "last on a vertex")
  `QLV_ASSERT(a_count_adv, done |=> (cnt_q == $past(cnt_q) + IDX_W'(4)) || (cnt_q == '0), "bad count")
  `QLV_ASSERT_NEVER(a_no_clear_held, busy_q && desc_q.is_clear, "clear held as primitive")

endmodule

>>> sv/quad_and_line_vertex_generator.sv
// Quad and thick-line vertex generator. Each request (tuser: 0 quad, 1 skewed
// quad, 2 thick line, 3 clear counter) other than a clear gives four vertices
// and then six triangle indices from a running vertex counter, tlast on the
// sixth; tuser on the output is high for index results. Lines with a squared
// length below 7 give nothing. A quad or clear goes straight from the accepting
// state to the emit state, and a primitive streams out at one result a cycle
// while the receiver is ready. A line ties up the front end longer, through
// the normalising shifts, the bit-per-cycle square root and the two serial
// divisions; a two-deep queue lets the next request be worked on while results
// drain.
// depends on qlvg_pkg, qlvg_front, qlvg_queue, qlvg_back
module quad_and_line_vertex_generator import qlvg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_x, a_y, b_x, b_y, shape_param, color_rgba, tex_u0, tex_v0, tex_u1, tex_v1
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [TYPE_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pos_x, pos_y, vertex_color, tex_u, tex_v, index_value
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // is_index
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  desc_t f_desc, b_desc;
  logic  f_valid, f_ready, b_valid, b_ready;

  qlvg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .req_data_i   (s_axis_tdata),
    .desc_valid_o (f_valid),
    .desc_ready_i (f_ready),
    .desc_o       (f_desc)
  );

  qlvg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_desc_i  (f_desc),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_desc_o   (b_desc)
  );

  qlvg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (b_valid),
    .desc_ready_o (b_ready),
    .desc_i       (b_desc),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_index_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> tb/tb_quad_and_line_vertex_generator.sv
// self-checking testbench for the quad and thick-line vertex generator
// drives requests on the input stream and checks every vertex and index result
// against an internal predictor, depends on qlvg_pkg and the generator rtl
`timescale 1ns / 1ps

module tb_quad_and_line_vertex_generator;
  import qlvg_pkg::*;

  // one request as the generator sees it
  typedef struct {
    logic [TYPE_W-1:0]    kind;
    logic signed [CW-1:0] ax, ay, bx, by, sp;
    logic [COL_W-1:0]     col;
    logic [TEX_W-1:0]     u0, v0, u1, v1;
  } prim_req_t;

  // one vertex or index result
  typedef struct packed {
    logic                 is_index;
    logic signed [CW-1:0] x, y;
    logic [COL_W-1:0]     col;
    logic [TEX_W-1:0]     u, v;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } vtx_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [TYPE_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  vtx_result_t      pending_results[$];
  logic [IDX_W-1:0] vertex_count;
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      prims_sent[4];
  bit               calm_input;
  bit               calm_output;
  bit               hold_output;

  quad_and_line_vertex_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // saturate an exact sum to the coordinate range
  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    longint hi;
    hi = (longint'(1) << (CW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[CW-1:0];
  endfunction

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void push_vertex(input longint x, input longint y,
                                      input logic [COL_W-1:0] col,
                                      input logic [TEX_W-1:0] u, input logic [TEX_W-1:0] v);
    vtx_result_t r;
    r = '{is_index: 1'b0, x: clamp_coord(x), y: clamp_coord(y), col: col,
          u: u, v: v, idx: '0, last: 1'b0};
    pending_results.insert(pending_results.size(), r);
  endfunction

  // six indices of the two triangles, then advance the counter
  function automatic void push_indices();
    int offs[6];
    vtx_result_t r;
    offs = '{0, 1, 2, 0, 2, 3};
    for (int i = 0; i < 6; i++) begin
      r = '{is_index: 1'b1, x: '0, y: '0, col: '0, u: '0, v: '0,
            idx: vertex_count + IDX_W'(offs[i]), last: (i == 5)};
      pending_results.insert(pending_results.size(), r);
    end
    vertex_count += IDX_W'(4);
  endfunction

  // expected results of one accepted request
  function automatic void predict_primitive(input prim_req_t q);
    longint ax, ay, bx, by, sp, skew, dx, dy, nx, ny;
    longint unsigned mx, my, mw, mmax, len;
    bit neg_w;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; sp = q.sp;
    case (q.kind) inside
      REQ_CLEAR: vertex_count = '0;
      REQ_QUAD, REQ_SKEW: begin
        skew = (q.kind == REQ_SKEW) ? sp : 0;
        push_vertex(ax + skew, ay, q.col, q.u0, q.v0);
        push_vertex(ax + bx + skew, ay, q.col, q.u1, q.v0);
        push_vertex(ax + bx, ay + by, q.col, q.u1, q.v1);
        push_vertex(ax, ay + by, q.col, q.u0, q.v1);
        push_indices();
      end
      default: begin
        dx = bx - ax;
        dy = by - ay;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        mw = (sp < 0) ? -sp : sp;
        neg_w = (sp < 0);
        mmax = (mx > my) ? mx : my;
        // too short to have a direction
        if (mmax < 3 && mx * mx + my * my < 7) return;
        while (mmax < (64'd1 << 30)) begin
          mx <<= 1; my <<= 1; mmax <<= 1;
        end
        if (mmax >= (64'd1 << 31)) begin
          mx >>= 1; my >>= 1;
        end
        len = floor_sqrt(mx * mx + my * my);
        nx = longint'((my * mw + len) / (2 * len));
        ny = longint'((mx * mw + len) / (2 * len));
        if ((dy > 0) != neg_w) nx = -nx;
        if ((dx < 0) != neg_w) ny = -ny;
        push_vertex(ax + nx, ay + ny, q.col, TEX_ZERO, TEX_ZERO);
        push_vertex(bx + nx, by + ny, q.col, TEX_ONE, TEX_ZERO);
        push_vertex(bx - nx, by - ny, q.col, TEX_ONE, TEX_ONE);
        push_vertex(ax - nx, ay - ny, q.col, TEX_ZERO, TEX_ONE);
        push_indices();
      end
    endcase
  endfunction

  // offer one request, keep valid high into the next one
  task automatic send_request(input prim_req_t q);
    while (!calm_input && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.kind;
    s_axis_tdata  <= {q.v1, q.u1, q.v0, q.u0, q.col, q.sp, q.by, q.bx, q.ay, q.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_primitive(q);
    prims_sent[q.kind]++;
  endtask

  function automatic prim_req_t make_req(input logic [TYPE_W-1:0] kind,
                                         input longint ax, input longint ay,
                                         input longint bx, input longint by,
                                         input longint sp);
    prim_req_t q;
    q.kind = kind;
    q.ax = ax[CW-1:0]; q.ay = ay[CW-1:0];
    q.bx = bx[CW-1:0]; q.by = by[CW-1:0];
    q.sp = sp[CW-1:0];
    q.col = COL_W'($urandom());
    q.u0 = TEX_W'($urandom()); q.v0 = TEX_W'($urandom());
    q.u1 = TEX_W'($urandom()); q.v1 = TEX_W'($urandom());
    return q;
  endfunction

  // mostly modest coordinates, sometimes the full range
  function automatic longint rand_coord();
    if ($urandom_range(99) < 70) return longint'($urandom_range(8192)) - 4096;
    return longint'(signed'(CW'($urandom())));
  endfunction

  function automatic prim_req_t rand_req();
    int pick;
    logic [TYPE_W-1:0] kind;
    prim_req_t q;
    pick = $urandom_range(99);
    kind = (pick < 35) ? REQ_QUAD : (pick < 60) ? REQ_SKEW : (pick < 92) ? REQ_LINE : REQ_CLEAR;
    q = make_req(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    // a few lines that are near the minimum length
    if (kind == REQ_LINE && $urandom_range(9) == 0) begin
      q.bx = q.ax + CW'($urandom_range(4)) - CW'(2);
      q.by = q.ay + CW'($urandom_range(4)) - CW'(2);
    end
    return q;
  endfunction

  // receiver readiness
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_output && (calm_output || $urandom_range(99) >= 23);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_output = 1'b0;
    forever begin
      wait (hold_output);
      repeat (400) @(posedge clk_i);
      hold_output = 1'b0;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    vtx_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_index = m_axis_tuser;
      got.last     = m_axis_tlast;
      got.x        = m_axis_tdata[CW-1:0];
      got.y        = m_axis_tdata[2*CW-1:CW];
      got.col      = m_axis_tdata[2*CW+COL_W-1:2*CW];
      got.u        = m_axis_tdata[2*CW+COL_W+TEX_W-1:2*CW+COL_W];
      got.v        = m_axis_tdata[2*CW+COL_W+2*TEX_W-1:2*CW+COL_W+TEX_W];
      got.idx      = m_axis_tdata[OUT_W-1:2*CW+COL_W+2*TEX_W];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // corners, saturation, negative sizes
  task automatic test_quads();
    longint big;
    prim_req_t q;
    big = (longint'(1) << (CW - 1)) - 1;
    send_request(make_req(REQ_QUAD, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_QUAD, 256, 512, 1024, 768, 0));
    send_request(make_req(REQ_QUAD, big, big, big, big, big));
    send_request(make_req(REQ_QUAD, -big - 1, -big - 1, -big - 1, -big - 1, 0));
    send_request(make_req(REQ_QUAD, 100, -100, -300, -50, 0));
    q = make_req(REQ_QUAD, -1, -1, 1, 1, -1);
    q.col = '1; q.u0 = '1; q.v0 = '1; q.u1 = '0; q.v1 = '0;
    send_request(q);
    q.col = '0; q.u0 = '0; q.v0 = '0; q.u1 = '1; q.v1 = '1;
    send_request(q);
  endtask

  task automatic test_skewed_quads();
    longint big;
    big = (longint'(1) << (CW - 1)) - 1;
    send_request(make_req(REQ_SKEW, 0, 0, 2560, 1280, 640));
    send_request(make_req(REQ_SKEW, 0, 0, 2560, 1280, -640));
    send_request(make_req(REQ_SKEW, big, 0, big, 10, big));
    send_request(make_req(REQ_SKEW, -big - 1, 0, -10, 10, -big - 1));
  endtask

  // short, axis-aligned, diagonal, huge and negative-width lines
  task automatic test_lines();
    longint big;
    big = (longint'(1) << (CW - 1)) - 1;
    send_request(make_req(REQ_LINE, 50, 50, 50, 50, 256));
    send_request(make_req(REQ_LINE, 0, 0, 2, 1, 256));
    send_request(make_req(REQ_LINE, 0, 0, 2, 2, 256));
    send_request(make_req(REQ_LINE, 0, 0, 2560, 0, 512));
    send_request(make_req(REQ_LINE, 0, 0, 0, -2560, 512));
    send_request(make_req(REQ_LINE, 100, 200, -700, 900, -768));
    send_request(make_req(REQ_LINE, -big - 1, -big - 1, big, big, big));
    send_request(make_req(REQ_LINE, big, -big - 1, -big - 1, big, -big - 1));
  endtask

  task automatic test_clear();
    send_request(make_req(REQ_CLEAR, 1, 2, 3, 4, 5));
    send_request(make_req(REQ_QUAD, 0, 0, 256, 256, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SKEW, 0, 0, 256, 256, 16));
  endtask

  // output held off while requests keep coming, so the queue backs up
  task automatic test_output_stall();
    calm_input = 1'b1;
    hold_output = 1'b1;
    repeat (12) send_request(make_req(REQ_QUAD, rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), 0));
    calm_input = 1'b0;
  endtask

  // random mix, with a calm stretch in the middle
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      calm_input  = (i >= count / 3 && i < count / 2);
      calm_output = calm_input;
      send_request(rand_req());
    end
    calm_input  = 1'b0;
    calm_output = 1'b0;
  endtask

  // run
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_QUAD;
    vertex_count  = '0;
    mismatches    = 0;
    results_seen  = 0;
    prims_sent    = '{0, 0, 0, 0};
    calm_input    = 1'b0;
    calm_output   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_quads();
    test_skewed_quads();
    test_lines();
    test_clear();
    test_output_stall();
    test_random_mix(270);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (250) @(posedge clk_i);
    $display("covered %0d quads, %0d skewed quads, %0d lines, %0d clears",
             prims_sent[REQ_QUAD], prims_sent[REQ_SKEW], prims_sent[REQ_LINE],
             prims_sent[REQ_CLEAR]);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("quad_and_line_vertex_generator regression: pass");
    end else begin
      $display("quad_and_line_vertex_generator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("quad_and_line_vertex_generator regression: fail");
    $finish;
  end

endmodule
